/* hw/rtl/fr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_pkg
// Shared types and constants of the fragment reassembler.
// ----------------------------------------------------------------------------
package fr_pkg;

  localparam int          HDR_LEN      = 12;
  localparam logic [11:0] POS_MAX      = 12'd4095;
  localparam logic [31:0] FRAG_TAG     = 32'h3142_5443;
  localparam int          MAX_FRAGMENT = 1024;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_SHORT_HEADER,
    ERR_BAD_TAG,
    ERR_BOUNDS,
    ERR_NONZERO_START,
    ERR_INCONSISTENT,
    ERR_CONFLICT
  } err_code_t;

  typedef enum logic {
    KIND_FRAGMENT,
    KIND_READ
  } kind_t;

  // Verdict on a completed fragment.
  typedef struct packed {
    err_code_t err;
    logic      commit;
    logic      set_total;
  } judge_res_t;

endpackage

/* hw/rtl/fragment_reassembler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fragment_reassembler
// In-order reassembly of a transfer from tagged, offset-carrying fragments.
// ----------------------------------------------------------------------------
// The input channel carries one beat per byte. A fragment beat (kind 0)
// delivers the next raw byte of the current fragment; its first twelve bytes
// form a little-endian header of tag, total size and offset, and the rest is
// payload. The beat with last_byte set closes the fragment and yields one
// result beat with the verdict, the received count and the transfer size.
// A read beat (kind 1) yields one result beat with the stored byte at
// read_index. Other fragment beats give no result.
// Each beat is registered in the input register and processed there; a beat
// with a result moves on into the result register, which presents it. One
// beat is taken every cycle unless a result beat waits behind a stalled
// result; the store is a single-write, dual-read memory whose read for the
// next payload position is issued as each beat is taken.
// While the result register is stalled, beats without a result keep flowing
// through the input register; the next result beat waits there and input
// ready stays low until the receiver takes the stalled result.
// Reset clears the header, position, size and count; the store itself is
// not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module fragment_reassembler import fr_pkg::*; #(
  parameter int MAX_TOTAL = 16384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [13:0] in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [2:0]  out_error_code,
  output logic [14:0] out_received_count,
  output logic [14:0] out_total_size,
  output logic [7:0]  out_read_data
);

  localparam int AW = $clog2(MAX_TOTAL);
  localparam int CW = $clog2(MAX_TOTAL + 1);

  // Input register stage.
  logic        s1_valid_r;
  kind_t       s1_kind_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic        s1_rd_oor_r;

  // Fragment and transfer state.
  logic [95:0]     hdr_r,          hdr_nxt;
  logic [11:0]     pos_r,          pos_nxt;
  logic            mismatch_r,     mismatch_nxt;
  logic [CW-1:0]   stored_total_r, stored_total_nxt;
  logic [CW-1:0]   received_r,     received_nxt;

  // Result register.
  logic        out_valid_r;
  logic        out_accepted_r;
  err_code_t   out_err_r;
  logic [14:0] out_rcv_r;
  logic [14:0] out_tot_r;
  logic [7:0]  out_rd_r;

  logic        is_frag;
  logic        has_result;
  logic        s1_adv;
  logic        in_fire;
  logic [32:0] addr;
  logic [32:0] addr_nxt;
  logic        in_payload;
  logic        below_mark;
  logic        in_store;
  logic        wr_en;
  logic        byte_mismatch;
  logic [95:0] hdr_w;
  logic [11:0] pos_inc;
  logic [11:0] pay;
  logic [31:0] rq32;
  logic [31:0] rcv32;
  logic [31:0] tot32;
  logic [7:0]  cmp_data;
  logic [7:0]  rdq_data;
  judge_res_t  verdict;

  // Handshake: the input stage moves on unless it holds a result that
  // cannot enter a full, stalled result register.
  assign is_frag    = (s1_kind_r == KIND_FRAGMENT);
  assign has_result = s1_valid_r && (!is_frag || s1_last_r);
  assign s1_adv     = s1_valid_r && (!has_result || !out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_adv;
  assign in_fire    = in_valid && in_ready;

  // Store position of the byte in the input stage.
  assign addr       = {1'b0, hdr_r[95:64]} + 33'(pos_r) - 33'(HDR_LEN);
  assign in_payload = (pos_r >= 12'(HDR_LEN)) && (pos_r != POS_MAX);
  assign below_mark = addr < 33'(received_r);
  assign in_store   = addr < 33'(MAX_TOTAL);
  assign wr_en      = s1_adv && is_frag && in_payload && !below_mark && in_store;
  assign byte_mismatch = is_frag && in_payload && below_mark && (cmp_data != s1_byte_r);
  assign pos_inc    = (pos_r == POS_MAX) ? pos_r : pos_r + 12'd1;
  assign pay        = pos_inc - 12'(HDR_LEN);

  always_comb begin
    hdr_w = hdr_r;
    for (int i = 0; i < HDR_LEN; i++) begin
      if (pos_r == 12'(i)) begin
        hdr_w[8*i +: 8] = s1_byte_r;
      end
    end
  end

  fr_judge #(
    .MAX_TOTAL (MAX_TOTAL)
  ) u_judge (
    .hdr_i          (hdr_w),
    .len_i          (pos_inc),
    .mismatch_i     (mismatch_r || byte_mismatch),
    .stored_total_i (stored_total_r),
    .received_i     (received_r),
    .res_o          (verdict)
  );

  always_comb begin
    hdr_nxt          = hdr_r;
    pos_nxt          = pos_r;
    mismatch_nxt     = mismatch_r;
    stored_total_nxt = stored_total_r;
    received_nxt     = received_r;
    if (s1_adv && is_frag) begin
      if (s1_last_r) begin
        // Every judged fragment leaves the per-fragment state clear.
        hdr_nxt      = '0;
        pos_nxt      = '0;
        mismatch_nxt = 1'b0;
        if (verdict.set_total) begin
          stored_total_nxt = CW'(hdr_w[63:32]);
        end
        if (verdict.commit) begin
          received_nxt = received_r + CW'(pay);
        end
      end else begin
        hdr_nxt      = hdr_w;
        pos_nxt      = pos_inc;
        mismatch_nxt = mismatch_r || byte_mismatch;
      end
    end
  end

  // The compare read for an incoming byte is aimed at the position that
  // the state will hold once the current stage has been processed.
  assign addr_nxt = {1'b0, hdr_nxt[95:64]} + 33'(pos_nxt) - 33'(HDR_LEN);
  assign rq32     = 32'(in_read_index);

  fr_store #(
    .MAX_TOTAL (MAX_TOTAL)
  ) u_store (
    .clk         (clk),
    .wr_en_i     (wr_en),
    .wr_idx_i    (addr[AW-1:0]),
    .wr_data_i   (s1_byte_r),
    .rd_en_i     (in_fire),
    .rd_a_idx_i  (addr_nxt[AW-1:0]),
    .rd_b_idx_i  (rq32[AW-1:0]),
    .rd_a_data_o (cmp_data),
    .rd_b_data_o (rdq_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r   <= kind_t'(in_kind);
      s1_byte_r   <= in_data_byte;
      s1_last_r   <= in_last_byte;
      s1_rd_oor_r <= rq32 >= 32'(MAX_TOTAL);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r          <= '0;
      pos_r          <= '0;
      mismatch_r     <= 1'b0;
      stored_total_r <= '0;
      received_r     <= '0;
    end else begin
      hdr_r          <= hdr_nxt;
      pos_r          <= pos_nxt;
      mismatch_r     <= mismatch_nxt;
      stored_total_r <= stored_total_nxt;
      received_r     <= received_nxt;
    end
  end

  assign rcv32 = 32'(received_nxt);
  assign tot32 = 32'(stored_total_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && has_result) begin
      out_accepted_r <= is_frag && (verdict.err == ERR_NONE);
      out_err_r      <= is_frag ? verdict.err : ERR_NONE;
      out_rcv_r      <= rcv32[14:0];
      out_tot_r      <= tot32[14:0];
      out_rd_r       <= (is_frag || s1_rd_oor_r) ? 8'd0 : rdq_data;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_accepted_r;
  assign out_error_code     = out_err_r;
  assign out_received_count = out_rcv_r;
  assign out_total_size     = out_tot_r;
  assign out_read_data      = out_rd_r;

`ifndef SYNTHESIS
  a_rcv_within_total: assert property (@(posedge clk) disable iff (!rst_n)
    received_r <= stored_total_r)
    else $error("received count exceeds the stored transfer size");

  a_rcv_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> received_r >= $past(received_r))
    else $error("received count went backwards");

  a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_accepted_r |-> out_err_r == ERR_NONE)
    else $error("accepted result carries an error code");

  a_frag_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && is_frag && s1_last_r |=> (pos_r == '0) && !mismatch_r)
    else $error("fragment state not cleared after the closing beat");
`endif

endmodule

/* hw/rtl/fr_judge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_judge
// Combinational verdict on a fragment once its final byte has arrived.
// ----------------------------------------------------------------------------
module fr_judge import fr_pkg::*; #(
  parameter int MAX_TOTAL = 16384,
  parameter int CW        = $clog2(MAX_TOTAL + 1)
) (
  input  logic [95:0]      hdr_i,
  input  logic [11:0]      len_i,
  input  logic             mismatch_i,
  input  logic [CW-1:0]    stored_total_i,
  input  logic [CW-1:0]    received_i,
  output judge_res_t       res_o
);

  logic [31:0] tot;
  logic [31:0] off;
  logic [11:0] pay;
  logic [32:0] end_pos;
  logic [31:0] st32;
  logic [31:0] rc32;
  logic [31:0] tot_eff;
  logic        first;
  logic        bounds;

  always_comb begin
    tot     = hdr_i[63:32];
    off     = hdr_i[95:64];
    pay     = len_i - 12'(HDR_LEN);
    end_pos = {1'b0, off} + 33'(pay);
    st32    = 32'(stored_total_i);
    rc32    = 32'(received_i);
    first   = (stored_total_i == '0);
    bounds  = (len_i == POS_MAX) || (tot == '0) || (tot > 32'(MAX_TOTAL)) ||
              (pay == '0) || (32'(pay) > 32'(MAX_FRAGMENT)) || (off > tot) ||
              (end_pos > {1'b0, tot});
    tot_eff = first ? tot : st32;

    res_o.err       = ERR_NONE;
    res_o.commit    = 1'b0;
    res_o.set_total = 1'b0;

    if (len_i < 12'd4) begin
      res_o.err = ERR_SHORT_HEADER;
    end else if (hdr_i[31:0] != FRAG_TAG) begin
      res_o.err = ERR_BAD_TAG;
    end else if (len_i < 12'(HDR_LEN)) begin
      res_o.err = ERR_SHORT_HEADER;
    end else if (bounds) begin
      res_o.err = ERR_BOUNDS;
    end else if (first && (off != '0)) begin
      res_o.err = ERR_NONZERO_START;
    end else begin
      // The first good fragment fixes the transfer size.
      res_o.set_total = first;
      if ((tot != tot_eff) || (off > rc32)) begin
        res_o.err = ERR_INCONSISTENT;
      end else if (off < rc32) begin
        if ((end_pos > {1'b0, rc32}) || mismatch_i) begin
          res_o.err = ERR_CONFLICT;
        end
      end else begin
        res_o.commit = 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/fr_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_store
// Assembly byte store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module fr_store #(
  parameter int MAX_TOTAL = 16384,
  parameter int AW        = $clog2(MAX_TOTAL)
) (
  input  logic          clk,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_idx_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_a_idx_i,
  input  logic [AW-1:0] rd_b_idx_i,
  output logic [7:0]    rd_a_data_o,
  output logic [7:0]    rd_b_data_o
);

  logic [7:0] mem [MAX_TOTAL];
  logic [7:0] rd_a_r;
  logic [7:0] rd_b_r;
  logic       fwd_a_r;
  logic       fwd_b_r;
  logic [7:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
  end

  // A write landing in the same cycle as a read of that entry is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en_i) begin
      rd_a_r     <= mem[rd_a_idx_i];
      rd_b_r     <= mem[rd_b_idx_i];
      fwd_a_r    <= wr_en_i && (wr_idx_i == rd_a_idx_i);
      fwd_b_r    <= wr_en_i && (wr_idx_i == rd_b_idx_i);
      fwd_data_r <= wr_data_i;
    end
  end

  assign rd_a_data_o = fwd_a_r ? fwd_data_r : rd_a_r;
  assign rd_b_data_o = fwd_b_r ? fwd_data_r : rd_b_r;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fragment reassembler.
// ----------------------------------------------------------------------------
// Byte beats are generated up front into a queue, and each one is run
// through a behavioural copy of the reassembler as it is generated. The
// verdict that a beat should cause travels with it and is only released to
// the scoreboard when the driver sees the beat accepted, so an early or
// spurious result beat cannot pair with a later expectation. The monitor
// compares every result beat, field by field, with the oldest expectation.
//
// Only one transfer exists per reset, since the stored size is never cleared.
// A directed opening covers the header error ladder, the staging corners
// (top of the store, dropped positions), the first commit and the
// duplicate cases.
// The random part then mostly sends well-formed fragments (new data at the
// received mark, matching duplicates) with broken ones and reads mixed in.
// Both handshakes are throttled with random gaps and calm stretches.
// ----------------------------------------------------------------------------
module tb_top import fr_pkg::*; ();

  localparam int XFER_MAX     = 16384;
  localparam int RANDOM_BEATS = 230;
  localparam int FIRST_SPAN   = 112;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic      accepted;
    err_code_t err;
    logic [14:0] rcvd;
    logic [14:0] total;
    logic [7:0]  rdata;
  } result_t;

  // One input beat, carrying the verdict it should cause, if any.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        last;
    logic [13:0] ridx;
    logic        has_result;
    result_t     verdict;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic [13:0] in_read_index = 14'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_accepted;
  logic [2:0]  out_error_code;
  logic [14:0] out_received_count;
  logic [14:0] out_total_size;
  logic [7:0]  out_read_data;

  always #5 clk = ~clk;

  fragment_reassembler #(
    .MAX_TOTAL(XFER_MAX)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_accepted      (out_accepted),
    .out_error_code    (out_error_code),
    .out_received_count(out_received_count),
    .out_total_size    (out_total_size),
    .out_read_data     (out_read_data)
  );

  // --------------------------------------------------------------------------
  // Behavioural reassembler. It tracks which store entries have ever been
  // written so that reads are only ever aimed at defined contents.
  // --------------------------------------------------------------------------
  logic [7:0]  frag_store [0:XFER_MAX-1];
  bit          store_valid [0:XFER_MAX-1];
  int unsigned store_filled [$];
  logic [7:0]  frag_hdr [0:HDR_LEN-1];
  int unsigned frag_pos;
  bit          frag_differs;
  int unsigned xfer_total;
  int unsigned xfer_rcvd;

  function automatic logic [31:0] hdr_word(input int at);
    return {frag_hdr[at+3], frag_hdr[at+2], frag_hdr[at+1], frag_hdr[at]};
  endfunction

  // Verdict on a closed fragment; commits the size and new data as it goes.
  function automatic err_code_t judge_fragment();
    longint unsigned tot;
    longint unsigned off;
    longint unsigned pay;
    if (frag_pos < 4) return ERR_SHORT_HEADER;
    if (hdr_word(0) != FRAG_TAG) return ERR_BAD_TAG;
    if (frag_pos < HDR_LEN) return ERR_SHORT_HEADER;
    tot = {32'd0, hdr_word(4)};
    off = {32'd0, hdr_word(8)};
    pay = 64'(frag_pos - HDR_LEN);
    if (frag_pos >= POS_MAX || tot == 0 || tot > XFER_MAX || pay == 0 ||
        pay > MAX_FRAGMENT || off > tot || pay > tot - off)
      return ERR_BOUNDS;
    if (xfer_total == 0) begin
      if (off != 0) return ERR_NONZERO_START;
      xfer_total = 32'(tot);
    end
    if (tot != xfer_total || off > xfer_rcvd) return ERR_INCONSISTENT;
    if (off < xfer_rcvd) begin
      // Pure duplicate: it must lie wholly below the mark and match.
      if (pay > xfer_rcvd - off || frag_differs) return ERR_CONFLICT;
      return ERR_NONE;
    end
    xfer_rcvd += 32'(pay);
    return ERR_NONE;
  endfunction

  // Advances the behavioural state by one beat; returns 1 if a result is due.
  function automatic bit reassemble_beat(input beat_t b, output result_t r);
    longint unsigned addr;
    err_code_t       err;
    r = '0;
    if (b.kind == KIND_READ) begin
      r.rcvd  = 15'(xfer_rcvd);
      r.total = 15'(xfer_total);
      r.rdata = frag_store[b.ridx];
      return 1'b1;
    end
    if (frag_pos < HDR_LEN) begin
      frag_hdr[frag_pos] = b.data;
    end else if (frag_pos < POS_MAX) begin
      addr = {32'd0, hdr_word(8)} + 64'(frag_pos - HDR_LEN);
      if (addr < xfer_rcvd) begin
        if (frag_store[addr[13:0]] != b.data) frag_differs = 1'b1;
      end else if (addr < XFER_MAX) begin
        // Staged ahead of the mark, whatever the verdict turns out to be.
        frag_store[addr[13:0]] = b.data;
        if (!store_valid[addr[13:0]]) begin
          store_valid[addr[13:0]] = 1'b1;
          store_filled.push_back(32'(addr));
        end
      end
    end
    if (frag_pos < POS_MAX) frag_pos++;
    if (!b.last) return 1'b0;
    err = judge_fragment();
    foreach (frag_hdr[i]) frag_hdr[i] = 8'd0;
    frag_pos     = 0;
    frag_differs = 1'b0;
    r.accepted = (err == ERR_NONE);
    r.err      = err;
    r.rcvd     = 15'(xfer_rcvd);
    r.total    = 15'(xfer_total);
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------
  beat_t       beats_to_send [$];
  result_t     verdicts_due [$];
  logic [7:0]  body_q [$];
  int unsigned n_beats, n_results, n_reads, n_frags, n_accepts;
  int unsigned err_hits [0:7];
  int unsigned faults;
  int unsigned cycle_count;
  int unsigned cycle_limit = 32'd2_000_000;

  task automatic queue_beat(input kind_t k, input logic [7:0] d, input logic l,
                            input logic [13:0] idx);
    beat_t   b;
    result_t r;
    b.kind       = k;
    b.data       = d;
    b.last       = l;
    b.ridx       = idx;
    b.has_result = reassemble_beat(b, r);
    b.verdict    = r;
    beats_to_send.push_back(b);
    n_beats++;
    if (b.has_result) begin
      n_results++;
      if (k == KIND_READ) begin
        n_reads++;
      end else begin
        n_frags++;
        if (r.accepted) n_accepts++;
        err_hits[r.err]++;
      end
    end
  endtask

  // Data and last are don't-care on a read, so they are randomised too.
  task automatic queue_read(input int unsigned idx);
    if (store_valid[idx[13:0]])
      queue_beat(KIND_READ, 8'($urandom), 1'($urandom), idx[13:0]);
  endtask

  task automatic queue_random_read();
    if (store_filled.size() > 0)
      queue_read(store_filled[$urandom_range(0, store_filled.size() - 1)]);
  endtask

  task automatic random_body(input int n);
    body_q.delete();
    repeat (n) body_q.push_back(8'($urandom));
  endtask

  // Payload copied from bytes already assembled below the mark.
  task automatic copied_body(input int unsigned from, input int n);
    body_q.delete();
    for (int i = 0; i < n; i++) body_q.push_back(frag_store[from + i]);
  endtask

  // Sends header plus body_q; a keep count between 1 and the full length
  // truncates the fragment. Reads are occasionally slipped in mid-fragment.
  task automatic emit_fragment(input logic [31:0] tag, input logic [31:0] total,
                               input logic [31:0] offset, input int keep);
    logic [7:0] raw [$];
    int         n;
    for (int i = 0; i < 4; i++) raw.push_back(tag[8*i +: 8]);
    for (int i = 0; i < 4; i++) raw.push_back(total[8*i +: 8]);
    for (int i = 0; i < 4; i++) raw.push_back(offset[8*i +: 8]);
    foreach (body_q[i]) raw.push_back(body_q[i]);
    n = (keep > 0 && keep < raw.size()) ? keep : raw.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 3) queue_random_read();
      queue_beat(KIND_FRAGMENT, raw[i], i == n - 1, 14'($urandom));
    end
  endtask

  function automatic int unsigned pick_span();
    if ($urandom_range(0, 9) == 0) return $urandom_range(17, 64);
    return $urandom_range(1, 16);
  endfunction

  // Broken fragments of assorted kinds, mostly aimed at the current transfer.
  task automatic emit_noise();
    logic [31:0] tag;
    tag = ($urandom_range(0, 1) == 1) ? FRAG_TAG : FRAG_TAG ^ (32'd1 << $urandom_range(0, 31));
    case ($urandom_range(0, 6))
      0: begin
        random_body(2);
        emit_fragment(tag, xfer_total, xfer_rcvd, $urandom_range(1, 11));
      end
      1: begin
        random_body($urandom_range(1, 8));
        emit_fragment(FRAG_TAG ^ (32'd1 << $urandom_range(0, 31)), xfer_total, xfer_rcvd, 0);
      end
      2: begin
        random_body($urandom_range(1, 4));
        emit_fragment(FRAG_TAG, xfer_total + $urandom_range(1, 50), xfer_rcvd, 0);
      end
      3: begin
        random_body($urandom_range(1, 4));
        emit_fragment(FRAG_TAG, xfer_total, xfer_rcvd + $urandom_range(1, 8), 0);
      end
      4: begin
        random_body(0);
        emit_fragment(FRAG_TAG, xfer_total, xfer_rcvd, 0);
      end
      5: begin
        random_body($urandom_range(3, 8));
        emit_fragment(FRAG_TAG, xfer_total, xfer_total - 2, 0);
      end
      default: begin
        random_body($urandom_range(1, 8));
        emit_fragment(tag, $urandom, ($urandom_range(0, 1) == 1) ? $urandom
                      : $urandom_range(0, XFER_MAX - 1), 0);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued beats, with random gaps between them and the
  // occasional calm stretch in which beats follow back to back.
  // --------------------------------------------------------------------------
  function automatic int unsigned random_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  beat_t       beat_now;
  int unsigned send_gap;
  int unsigned send_calm;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready && beat_now.has_result)
        verdicts_due.push_back(beat_now.verdict);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (beats_to_send.size() > 0) begin
          beat_now = beats_to_send.pop_front();
          in_kind       <= beat_now.kind;
          in_data_byte  <= beat_now.data;
          in_last_byte  <= beat_now.last;
          in_read_index <= beat_now.ridx;
          in_valid      <= 1'b1;
          if (send_calm > 0) begin
            send_calm--;
          end else if ($urandom_range(0, 99) < 2) begin
            send_calm = $urandom_range(50, 150);
          end else begin
            send_gap = random_idle();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: throttles out_ready and scores every result beat taken.
  // --------------------------------------------------------------------------
  result_t     verdict_head;
  int unsigned take_hold;
  int unsigned take_calm;

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      faults++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, accepted %0d code %0d",
                   $time, out_accepted, out_error_code);
          faults++;
        end else begin
          verdict_head = verdicts_due.pop_front();
          compare_field("accepted", 32'(verdict_head.accepted), 32'(out_accepted));
          compare_field("error_code", 32'(verdict_head.err), 32'(out_error_code));
          compare_field("received_count", 32'(verdict_head.rcvd),
                        32'(out_received_count));
          compare_field("total_size", 32'(verdict_head.total), 32'(out_total_size));
          compare_field("read_data", 32'(verdict_head.rdata), 32'(out_read_data));
        end
      end
      if (take_hold > 0) begin
        take_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (take_calm > 0) begin
          take_calm--;
        end else if ($urandom_range(0, 99) < 2) begin
          take_calm = $urandom_range(50, 150);
        end else if ($urandom_range(0, 99) < 30) begin
          take_hold = random_idle() + 1;
        end
      end
    end
  end

  // A hung handshake ends the run here rather than hanging the simulator.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("Timed out after %0d cycles with %0d beats unsent, %0d results owed",
               cycle_count, beats_to_send.size(), verdicts_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned plan_total;
    int unsigned beats_mark;
    int unsigned pick;
    int unsigned room;
    int unsigned span;
    int unsigned from;
    int unsigned k;
    int unsigned extra;
    int unsigned waited;

    frag_pos     = 0;
    frag_differs = 1'b0;
    xfer_total   = 0;
    xfer_rcvd    = 0;
    foreach (frag_hdr[i]) frag_hdr[i] = 8'd0;
    foreach (err_hits[i]) err_hits[i] = 0;
    plan_total = MAX_FRAGMENT + $urandom_range(100, 180);

    // Header error ladder, before anything has been accepted.
    random_body(4);
    emit_fragment(FRAG_TAG, plan_total, 0, 1);
    emit_fragment(FRAG_TAG, plan_total, 0, 3);
    emit_fragment(FRAG_TAG ^ 32'h8000_0000, plan_total, 0, 4);
    emit_fragment(32'h0, plan_total, 0, 0);
    emit_fragment(FRAG_TAG, plan_total, 0, 9);
    random_body(0);
    emit_fragment(FRAG_TAG, plan_total, 0, 0);
    random_body(3);
    emit_fragment(FRAG_TAG, 0, 0, 0);
    emit_fragment(FRAG_TAG, 32'hFFFF_FFFF, 0, 0);
    emit_fragment(FRAG_TAG, XFER_MAX + 1, 0, 0);
    emit_fragment(FRAG_TAG, 10, 11, 0);
    random_body(8);
    emit_fragment(FRAG_TAG, 10, 5, 0);
    // Staging corners: everything dropped, then half landing at the top.
    emit_fragment(FRAG_TAG, 100, 32'hFFFF_FFFF, 0);
    emit_fragment(FRAG_TAG, 100, XFER_MAX - 4, 0);
    queue_read(XFER_MAX - 1);
    queue_read(XFER_MAX - 4);
    random_body(4);
    emit_fragment(FRAG_TAG, plan_total, 5, 0);
    // First commit.
    random_body(FIRST_SPAN);
    emit_fragment(FRAG_TAG, plan_total, 0, 0);
    queue_read(0);
    queue_read(FIRST_SPAN - 1);
    // A size that passes the bounds check but disagrees, then a hole.
    random_body(4);
    emit_fragment(FRAG_TAG, XFER_MAX, 0, 0);
    random_body(2);
    emit_fragment(FRAG_TAG, plan_total, xfer_rcvd + 1, 0);
    // Duplicates: matching, differing, and one running past the mark.
    copied_body(10, 20);
    emit_fragment(FRAG_TAG, plan_total, 10, 0);
    copied_body(100, 8);
    body_q[3] ^= 8'h5A;
    emit_fragment(FRAG_TAG, plan_total, 100, 0);
    copied_body(xfer_rcvd - 3, 3);
    repeat (3) body_q.push_back(8'($urandom));
    emit_fragment(FRAG_TAG, plan_total, xfer_rcvd - 3, 0);
    random_body(1);
    emit_fragment(FRAG_TAG, plan_total, xfer_rcvd, 0);

    // Random part, weighted towards well-formed traffic.
    beats_mark = n_beats;
    while ((n_beats - beats_mark) < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      room = xfer_total - xfer_rcvd;
      if (pick < 10) begin
        repeat ($urandom_range(1, 3)) queue_random_read();
      end else if (pick < 55 && room > 0) begin
        span = pick_span();
        if (span > room) span = room;
        random_body(span);
        emit_fragment(FRAG_TAG, xfer_total, xfer_rcvd, 0);
      end else if (pick < 80) begin
        from = $urandom_range(0, xfer_rcvd - 1);
        span = pick_span();
        if (span > xfer_rcvd - from) span = xfer_rcvd - from;
        copied_body(from, span);
        if (pick >= 74) body_q[$urandom_range(0, span - 1)] ^= 8'(1 << $urandom_range(0, 7));
        emit_fragment(FRAG_TAG, xfer_total, from, 0);
      end else if (pick < 84 && room > 0) begin
        k     = $urandom_range(1, 8);
        extra = $urandom_range(1, (room < 8) ? room : 8);
        copied_body(xfer_rcvd - k, k);
        repeat (extra) body_q.push_back(8'($urandom));
        emit_fragment(FRAG_TAG, xfer_total, xfer_rcvd - k, 0);
      end else begin
        emit_noise();
      end
    end

    // Worst case is every beat waiting out the longest gap and every result
    // the longest stall; the limit sits well beyond that.
    cycle_limit = 300 * n_beats + 20000;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (beats_to_send.size() != 0 || in_valid);
    waited = 0;
    while (verdicts_due.size() != 0 && waited < 1000) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (verdicts_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, verdicts_due.size());
      faults++;
    end

    $display("Covered %0d beats: %0d fragments judged, %0d accepted, %0d reads; %0d of %0d bytes assembled.",
             n_beats, n_frags, n_accepts, n_reads, xfer_rcvd, xfer_total);
    $display("Verdicts: ok %0d, short %0d, tag %0d, bounds %0d, start %0d, inconsistent %0d, conflict %0d.",
             err_hits[ERR_NONE], err_hits[ERR_SHORT_HEADER], err_hits[ERR_BAD_TAG],
             err_hits[ERR_BOUNDS], err_hits[ERR_NONZERO_START], err_hits[ERR_INCONSISTENT],
             err_hits[ERR_CONFLICT]);
    if (faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/fr_pkg.sv
hw/rtl/fr_judge.sv
hw/rtl/fr_store.sv
hw/rtl/fragment_reassembler.sv
tb/tb_top.sv
